// File: rtl/core/anvcp_pkg.sv
// Shared types and constants for the name=value command parser.
// No dependencies.
`default_nettype none
package anvcp_pkg;
	localparam logic [7:0] CH_BANG = 8'h21;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_US   = 8'h5F;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam int TABLE_LEN = 3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNKNOWN = 3'd1;
	localparam logic [2:0] ST_SYNTAX  = 3'd2;
	localparam logic [2:0] ST_OVF     = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;
	localparam logic [1:0] IDX_NONE   = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic byte_en;   // consume a byte other than '!', CR or LF
		logic clear;     // restart command
		logic conv_init; // load fraction converter
		logic conv_step; // one fraction digit
		logic commit;    // produce result and store
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic conv_done;
	} dp_stat_t;

	function automatic logic [7:0] name_char(input int t, input int p);
		logic [7:0] c;
		c = 8'h00;
		case (t)
			0: case (p) 0: c = "s"; 1: c = "p"; 2: c = "e"; 3: c = "e"; 4: c = "d";
				default: c = 8'h00; endcase
			1: case (p) 0: c = "a"; 1: c = "n"; 2: c = "g"; 3: c = "l"; 4: c = "e";
				default: c = 8'h00; endcase
			2: case (p) 0: c = "m"; 1: c = "i"; 2: c = "t"; default: c = 8'h00; endcase
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic int name_len(input int t);
		return (t == 2) ? 3 : 5;
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/anvcp_ctrl.sv
// Controller state machine for the command parser.
// Depends on anvcp_pkg.
`default_nettype none
module anvcp_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] rx_byte,
	output logic out_valid,
	input  wire logic out_stall,
	output anvcp_pkg::dp_cmd_t cmd,
	input  anvcp_pkg::dp_stat_t stat
);
	import anvcp_pkg::*;
	typedef enum logic [1:0] {S_IDLE, S_INIT, S_CONV, S_OUT} state_t;
	state_t state_q;
	logic acc, bang;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;
	assign bang = rx_byte == CH_BANG;

	always_comb begin
		cmd = '0;
		cmd.byte_en = acc && !bang && rx_byte != CH_CR && rx_byte != CH_LF;
		cmd.conv_init = (state_q == S_INIT);
		cmd.conv_step = (state_q == S_CONV) && !stat.conv_done;
		cmd.commit = (state_q == S_CONV) && stat.conv_done;
		cmd.clear = cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc && bang) state_q <= S_INIT;
				S_INIT: state_q <= S_CONV;
				S_CONV: if (stat.conv_done) begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (!out_stall) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	property p_valid_in_out;
		@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == S_OUT;
	endproperty
	a_valid_in_out: assert property (p_valid_in_out) else $error("out_valid outside S_OUT");
	a_commit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !cmd.commit) else $error("double commit");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("accept while result pending");
endmodule
`default_nettype wire

// File: rtl/core/anvcp_dp.sv
// Datapath: byte checks, accumulators, fraction converter, parameter store.
// Depends on anvcp_pkg.
`default_nettype none
module anvcp_dp #(
	parameter int MAX_CMD_LEN = 64,
	parameter int FRAC_BITS = 16,
	parameter int NUM_PARAMS = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [7:0] rx_byte,
	input  anvcp_pkg::dp_cmd_t cmd,
	output anvcp_pkg::dp_stat_t stat,
	output logic [2:0] status,
	output logic [1:0] param_index,
	output logic signed [31:0] param_value,
	output logic [2:0] received_mask
);
	import anvcp_pkg::*;
	localparam int ACTIVE = (NUM_PARAMS < TABLE_LEN) ? NUM_PARAMS : TABLE_LEN;
	localparam logic [2:0] ACT_MASK = 3'((1 << ACTIVE) - 1);
	localparam int LW = $clog2(MAX_CMD_LEN);
	localparam int FD = (FRAC_BITS > 0) ? FRAC_BITS : 1;
	localparam int FCW = $clog2(FD + 1);
	localparam int FIW = (FD > 1) ? $clog2(FD) : 1;
	localparam logic [32:0] INT_LIMIT = 33'(64'd1 << (31 - FRAC_BITS));

	logic [LW-1:0] len_q;
	logic ovf_q, valph_q, err_q, neg_q, started_q, dot_q, dseen_q;
	logic [2:0] match_q, marks_q;
	logic [32:0] int_q;
	logic [3:0] fdig_q [FD];
	logic [FCW-1:0] fcnt_q, ci_q;
	logic [31:0] r_q;
	logic [31:0] store_q [TABLE_LEN];

	logic is_alpha, is_dig, len_full;
	logic [3:0] d;
	assign is_alpha = (rx_byte >= "A" && rx_byte <= "Z") ||
		(rx_byte >= "a" && rx_byte <= "z") || rx_byte == CH_US;
	assign is_dig = rx_byte >= "0" && rx_byte <= "9";
	assign d = rx_byte[3:0] - 4'd0;
	assign len_full = 32'(len_q) >= 32'(MAX_CMD_LEN - 1);
	assign stat.conv_done = (ci_q == '0);

	logic [36:0] imul;
	assign imul = {4'd0, int_q} * 37'd10 + 37'(d);

	// fraction step: (digit<<F + r)/10 via reciprocal with correction
	logic [FCW-1:0] ci_m1;
	logic [31:0] fnum;
	logic [63:0] fprod;
	logic [31:0] fq0, frem;
	assign ci_m1 = ci_q - FCW'(1);
	assign fnum = (32'(fdig_q[ci_m1[FIW-1:0]]) << FRAC_BITS) + r_q;
	assign fprod = {32'd0, fnum} * 64'hCCCCCCCD;
	assign fq0 = {3'd0, fprod[63:35]};
	assign frem = fnum - fq0 * 32'd10;

	logic [63:0] mag;
	logic bad;
	logic [31:0] val;
	assign mag = ({31'd0, int_q} << FRAC_BITS) + 64'(r_q);
	always_comb begin
		if (neg_q) begin
			bad = mag > 64'h80000000;
			val = 32'd0 - mag[31:0];
		end else begin
			bad = mag > 64'h7FFFFFFF;
			val = mag[31:0];
		end
	end

	logic hit;
	logic [1:0] hit_idx;
	always_comb begin
		hit = 1'b0;
		hit_idx = 2'd0;
		for (int i = TABLE_LEN - 1; i >= 0; i--) begin
			if (i < ACTIVE && match_q[i]) begin
				hit = 1'b1;
				hit_idx = 2'(i);
			end
		end
	end

	logic [2:0] res_st;
	logic [1:0] res_idx;
	logic [31:0] res_val;
	always_comb begin
		res_st = ST_SYNTAX;
		res_idx = IDX_NONE;
		res_val = '0;
		if (ovf_q) res_st = ST_OVF;
		else if (len_q == '0) res_st = ST_EMPTY;
		else if (valph_q && dseen_q && !err_q && !bad) begin
			res_val = val;
			if (hit) begin
				res_st = ST_OK;
				res_idx = hit_idx;
			end else res_st = ST_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; ovf_q <= 1'b0; valph_q <= 1'b0; err_q <= 1'b0;
			neg_q <= 1'b0; started_q <= 1'b0; dot_q <= 1'b0; dseen_q <= 1'b0;
			match_q <= ACT_MASK; marks_q <= '0; int_q <= '0; fcnt_q <= '0;
			ci_q <= '0; r_q <= '0;
			status <= '0; param_index <= '0; param_value <= '0; received_mask <= '0;
			for (int i = 0; i < TABLE_LEN; i++) store_q[i] <= '0;
			for (int i = 0; i < FD; i++) fdig_q[i] <= '0;
		end else begin
			if (cmd.conv_init) begin
				ci_q <= (FRAC_BITS > 0) ? fcnt_q : '0;
				r_q <= '0;
			end
			if (cmd.conv_step) begin
				r_q <= (frem >= 32'd10) ? fq0 + 32'd1 : fq0;
				ci_q <= ci_q - FCW'(1);
			end
			if (cmd.commit) begin
				status <= res_st;
				param_index <= res_idx;
				param_value <= res_val;
				if (res_st == ST_OK) begin
					store_q[hit_idx] <= val;
					marks_q <= marks_q | (3'd1 << hit_idx);
					received_mask <= marks_q | (3'd1 << hit_idx);
				end else received_mask <= marks_q;
			end
			if (cmd.clear) begin
				len_q <= '0; ovf_q <= 1'b0; valph_q <= 1'b0; err_q <= 1'b0;
				neg_q <= 1'b0; started_q <= 1'b0; dot_q <= 1'b0; dseen_q <= 1'b0;
				match_q <= ACT_MASK; int_q <= '0; fcnt_q <= '0;
				for (int i = 0; i < FD; i++) fdig_q[i] <= '0;
			end
			if (cmd.byte_en && !ovf_q) begin
				if (len_full) begin
					ovf_q <= 1'b1;
					len_q <= '0;
				end else begin
					len_q <= len_q + LW'(1);
					if (valph_q) begin
						if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
							if (started_q) err_q <= 1'b1;
							started_q <= 1'b1;
							if (rx_byte == CH_MINUS) neg_q <= 1'b1;
						end else if (rx_byte == CH_DOT) begin
							if (dot_q) err_q <= 1'b1;
							dot_q <= 1'b1;
							started_q <= 1'b1;
						end else if (is_dig) begin
							started_q <= 1'b1;
							dseen_q <= 1'b1;
							if (!dot_q)
								int_q <= (imul > 37'(INT_LIMIT)) ? INT_LIMIT + 33'd1
									: imul[32:0];
							else if (32'(fcnt_q) < FRAC_BITS) begin
								fdig_q[fcnt_q[FIW-1:0]] <= d;
								fcnt_q <= fcnt_q + FCW'(1);
							end
						end else err_q <= 1'b1;
					end else if (rx_byte == CH_EQ) begin
						if (len_q == '0) err_q <= 1'b1;
						for (int i = 0; i < TABLE_LEN; i++)
							if (32'(len_q) != name_len(i)) match_q[i] <= 1'b0;
						valph_q <= 1'b1;
					end else begin
						if (len_q == '0 ? !is_alpha : !(is_alpha || is_dig)) err_q <= 1'b1;
						for (int i = 0; i < TABLE_LEN; i++)
							if (!(32'(len_q) < name_len(i) &&
								name_char(i, 32'(len_q)) == rx_byte))
								match_q[i] <= 1'b0;
					end
				end
			end
		end
	end

	a_len_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == '0) else $error("length kept after overflow");
	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		(match_q & ~ACT_MASK) == '0) else $error("inactive name matched");
	a_marks_mono: assert property (@(posedge clk) disable iff (!arst_n)
		($past(marks_q) & ~marks_q) == '0) else $error("received mark cleared");
endmodule
`default_nettype wire

// File: rtl/core/ascii_name_value_command_parser.sv
// Top level of the name=value command parser.
// Depends on anvcp_pkg, anvcp_ctrl, anvcp_dp.
//
// Input channel: rx_byte with in_valid/in_stall, one byte per transaction.
// Output channel: status, param_index, param_value, received_mask with
// out_valid/out_stall, one transaction for each '!' byte.
// Ordinary bytes are taken one per cycle. A '!' starts the finish sequence:
// a load step, a divide step for each stored fraction digit (up to FRAC_BITS) in
// the shared divide-by-ten unit, then a commit step; the result is
// registered and shown until taken. Input is stalled from the '!' until
// the result transaction completes, including any output stall.
// Reset clears the command in progress, the stored values and the
// received marks. A stalled result holds its payload unchanged.
`default_nettype none
module ascii_name_value_command_parser #(
	parameter int MAX_CMD_LEN = 64,
	parameter int FRAC_BITS = 16,
	parameter int NUM_PARAMS = 3
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] rx_byte,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [2:0] status,
	output logic [1:0] param_index,
	output logic signed [31:0] param_value,
	output logic [2:0] received_mask
);
	import anvcp_pkg::*;
	dp_cmd_t cmd;
	dp_stat_t stat;

	anvcp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .rx_byte,
		.out_valid, .out_stall, .cmd, .stat
	);

	anvcp_dp #(
		.MAX_CMD_LEN(MAX_CMD_LEN), .FRAC_BITS(FRAC_BITS), .NUM_PARAMS(NUM_PARAMS)
	) u_dp (
		.clk, .arst_n, .rx_byte, .cmd, .stat,
		.status, .param_index, .param_value, .received_mask
	);
endmodule
`default_nettype wire

// File: test/tb_ascii_name_value_command_parser.sv
// Testbench for the name=value command parser: byte stream in, one status per '!'.
// Depends on anvcp_pkg and ascii_name_value_command_parser; checks against an internal predictor.
`default_nettype none
module tb_ascii_name_value_command_parser;
	timeunit 1ns;
	timeprecision 1ps;
	import anvcp_pkg::*;

	localparam int MAX_LEN = 64;
	localparam int FRAC = 16;
	localparam int NPAR = 3;

	typedef struct packed {
		logic [2:0] st;
		logic [1:0] idx;
		logic [31:0] val;
		logic [2:0] mask;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic out_stall = 1'b0;
	logic in_stall, out_valid;
	logic [2:0] status, received_mask;
	logic [1:0] param_index;
	logic signed [31:0] param_value;

	ascii_name_value_command_parser #(.MAX_CMD_LEN(MAX_LEN), .FRAC_BITS(FRAC),
		.NUM_PARAMS(NPAR)) dut (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// predictor state
	int cmd_len;
	bit ovf, val_phase, syn_err, neg, started, dot, dig_seen;
	logic [2:0] match;
	logic [31:0] int_acc;
	int frac_cnt;
	int frac_dig[FRAC + 1];
	logic [31:0] param_store[3];
	logic [2:0] marks;

	status_t expected_status[$];
	int errors = 0;
	int n_sent = 0;
	bit calm = 1'b0;

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_US;
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void restart_command();
		cmd_len = 0; ovf = 0; val_phase = 0; syn_err = 0;
		neg = 0; started = 0; dot = 0; dig_seen = 0;
		match = 3'b111; int_acc = 0; frac_cnt = 0;
		foreach (frac_dig[i]) frac_dig[i] = 0;
	endfunction

	function automatic status_t finish_command();
		status_t r;
		logic [31:0] acc;
		logic [63:0] mag;
		r = '{st: ST_SYNTAX, idx: IDX_NONE, val: 32'd0, mask: 3'd0};
		acc = 0;
		if (!val_phase || !dig_seen || syn_err) return r;
		for (int i = frac_cnt; i > 0; i--)
			acc = ((32'(frac_dig[i - 1]) << FRAC) + acc) / 10;
		mag = (64'(int_acc) << FRAC) + acc;
		if (neg) begin
			if (mag > 64'h8000_0000) return r;
			r.val = 32'd0 - mag[31:0];
		end else begin
			if (mag > 64'h7FFF_FFFF) return r;
			r.val = mag[31:0];
		end
		for (int i = 0; i < NPAR; i++) begin
			if (match[i]) begin
				param_store[i] = r.val;
				marks[i] = 1'b1;
				r.idx = 2'(i);
				r.st = ST_OK;
				return r;
			end
		end
		r.st = ST_UNKNOWN;
		return r;
	endfunction

	// returns 1 and the status when the byte ends a command
	function automatic bit parse_byte(logic [7:0] c, output status_t r);
		logic [63:0] n;
		r = '0;
		if (c == CH_CR || c == CH_LF) return 0;
		if (c == CH_BANG) begin
			r = '{st: ST_SYNTAX, idx: IDX_NONE, val: 32'd0, mask: 3'd0};
			if (ovf) r.st = ST_OVF;
			else if (cmd_len == 0) r.st = ST_EMPTY;
			else r = finish_command();
			r.mask = marks;
			restart_command();
			return 1;
		end
		if (ovf) return 0;
		if (cmd_len >= MAX_LEN - 1) begin
			ovf = 1; cmd_len = 0;
			return 0;
		end
		if (val_phase) begin
			if (c == CH_PLUS || c == CH_MINUS) begin
				if (started) syn_err = 1;
				started = 1;
				if (c == CH_MINUS) neg = 1;
			end else if (c == CH_DOT) begin
				if (dot) syn_err = 1;
				dot = 1; started = 1;
			end else if (is_num(c)) begin
				started = 1; dig_seen = 1;
				if (!dot) begin
					n = 64'(int_acc) * 10 + (c - "0");
					int_acc = (n > (64'd1 << (31 - FRAC))) ?
						(32'd1 << (31 - FRAC)) + 1 : n[31:0];
				end else if (frac_cnt < FRAC) begin
					frac_dig[frac_cnt] = c - "0";
					frac_cnt++;
				end
			end else syn_err = 1;
		end else if (c == CH_EQ) begin
			if (cmd_len == 0) syn_err = 1;
			for (int i = 0; i < TABLE_LEN; i++)
				if (name_len(i) != cmd_len) match[i] = 0;
			val_phase = 1;
		end else begin
			if (cmd_len == 0 ? !is_alpha(c) : !(is_alpha(c) || is_num(c))) syn_err = 1;
			for (int i = 0; i < TABLE_LEN; i++)
				if (!(cmd_len < name_len(i) && name_char(i, cmd_len) == c)) match[i] = 0;
		end
		cmd_len++;
		return 0;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// output side: random stall and checking
	always @(posedge clk) begin
		status_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_status.size() == 0) report_mismatch("unexpected transaction", status, 0);
			else begin
				e = expected_status.pop_front();
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (param_index !== e.idx) report_mismatch("param_index", param_index, e.idx);
				if (param_value !== e.val) report_mismatch("param_value", param_value, e.val);
				if (received_mask !== e.mask) report_mismatch("received_mask", received_mask, e.mask);
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 31);
	end

	task automatic send_byte(logic [7:0] c);
		status_t r;
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
		if (parse_byte(c, r)) expected_status.push_back(r);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	// directed table: text, and a typed status where obvious (-1: predictor only)
	typedef struct {
		string text;
		int want_st;
	} row_t;
	row_t rows[] = '{
		'{"!", ST_EMPTY}, '{"\x0d\x0a!", ST_EMPTY}, '{"=5!", ST_SYNTAX}, '{"speed!", ST_SYNTAX},
		'{"speed=!", ST_SYNTAX}, '{"9ab=1!", ST_SYNTAX}, '{"sp ed=1!", ST_SYNTAX},
		'{"speed=1.5!", -1}, '{"angle=-2.25!", -1}, '{"mit=+0.0001!", -1},
		'{"foo_1=3!", -1}, '{"_x=7.!", -1}, '{"speed=1=2!", ST_SYNTAX},
		'{"speed=1-2!", ST_SYNTAX}, '{"speed=1..2!", ST_SYNTAX}, '{"speed=1e3!", ST_SYNTAX},
		'{"speed=-!", ST_SYNTAX}, '{"speed=32767.99999999999999999!", -1},
		'{"speed=32768!", ST_SYNTAX}, '{"angle=-32768!", -1}, '{"angle=-32768.00002!", -1},
		'{"mit=\x00!", ST_SYNTAX},
		'{"speedy_name_that_goes_on_and_on_and_on_and_on_and_on_and_on_xyz=1!", ST_OVF},
		'{"\xff\x80=1!", ST_SYNTAX}
	};

	function automatic string rand_digits(int n);
		string s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
		return s;
	endfunction

	task automatic send_random_command();
		string s, nm;
		int k = $urandom_range(99);
		case ($urandom_range(3))
			0: nm = "speed";
			1: nm = "angle";
			2: nm = "mit";
			default: nm = {"v", rand_digits($urandom_range(3))};
		endcase
		s = {nm, "="};
		case ($urandom_range(2))
			0: s = {s, "-"};
			1: s = {s, "+"};
			default: ;
		endcase
		s = {s, rand_digits($urandom_range(1, 6))};
		if ($urandom_range(1)) s = {s, ".", rand_digits($urandom_range(0, 20))};
		if (k < 10) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
		else if (k < 14) s = {s, rand_digits(60)};
		send_text({s, "!"});
	endtask

	initial begin
		restart_command();
		param_store = '{default: 0};
		marks = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_text(rows[i].text);
			if (rows[i].want_st >= 0 && expected_status[$].st !== 3'(rows[i].want_st))
				report_mismatch("directed status", expected_status[$].st, rows[i].want_st);
		end
		while (n_sent < 1050) begin
			calm = (n_sent > 400 && n_sent < 520);
			if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
			else send_random_command();
		end
		send_byte(CH_BANG);
		in_valid <= 1'b0;
		calm = 1'b0;
		while (expected_status.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
